// ===== design/jehb_pkg.sv =====
package jehb_pkg;

  localparam int PART_W    = 16;
  localparam int ENERGY_W  = 32;
  localparam int COUNT_W   = 32;
  localparam int RADDR_W   = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic signed [ENERGY_W-1:0] energy_t;
  typedef logic [PART_W-1:0]          part_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam cfg_idx_t CFG_PART_FLOOR    = 2'd0;
  localparam cfg_idx_t CFG_ENERGY_FLOOR  = 2'd1;
  localparam cfg_idx_t CFG_INV_BIN_WIDTH = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam count_t   COUNT_MAX     = '1;
  localparam logic [31:0] INV_WIDTH_RESET = 32'h0001_0000;

endpackage

// ===== design/joint_energy_histogram_binner.sv =====
// Channel   Handshake                     Word
// --------  ----------------------------  ------------------------------------------------
// command   start && !busy                opcode, particles_a/b, energy_a/b, read_address
// result    done (one cycle, no stall)    accepted, bin_count
// config    cfg_valid && cfg_ready        cfg_index, cfg_data
//
// Each command passes through the difference, multiply, address and
// read-modify-write stages of the simple dual-port counter memory,
// and a new command is taken in the cycle its result shows on done.
// After reset the block sweeps the counter memory to zero, one entry a cycle
// (PART_BINS^2 * ENERGY_BINS^2 entries, 65536 by default) with busy held high.
// Configuration words are taken in any cycle; cfg_ready is always high.
// The result receiver cannot stall: done pulses for exactly one cycle.
module joint_energy_histogram_binner
  import jehb_pkg::*;
#(
  parameter int PART_BINS   = 8,
  parameter int ENERGY_BINS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // command
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode,
  input  part_t                particles_a,
  input  part_t                particles_b,
  input  energy_t              energy_a,
  input  energy_t              energy_b,
  input  logic [RADDR_W-1:0]   read_address,
  // result
  output logic                 done,
  output logic                 accepted,
  output count_t               bin_count,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_idx_t             cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam longint unsigned NUM_BINS = longint'(PART_BINS) * longint'(PART_BINS)
                                       * longint'(ENERGY_BINS) * longint'(ENERGY_BINS);
  localparam int AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int PB_W = (PART_BINS > 1) ? $clog2(PART_BINS) : 1;
  localparam int EB_W = (ENERGY_BINS > 1) ? $clog2(ENERGY_BINS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADDR  = 3'd4;
  localparam logic [2:0] S_RMW   = 3'd5;

  logic [2:0] state, state_next;

  // Configuration registers
  part_t       part_floor;
  energy_t     energy_floor;
  logic [31:0] inv_bin_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_floor    <= '0;
      energy_floor  <= '0;
      inv_bin_width <= INV_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PART_FLOOR:    part_floor    <= cfg_data[PART_W-1:0];
        CFG_ENERGY_FLOOR:  energy_floor  <= energy_t'(cfg_data);
        CFG_INV_BIN_WIDTH: inv_bin_width <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  wire take = start && !busy;

  // Capture the command word
  logic               op;
  part_t              pa_in, pb_in;
  energy_t            ea_in, eb_in;
  logic [RADDR_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (take) begin
      op      <= opcode;
      pa_in   <= particles_a;
      pb_in   <= particles_b;
      ea_in   <= energy_a;
      eb_in   <= energy_b;
      rd_addr <= read_address;
    end
  end

  // Difference stage: particle bins and energy offsets
  logic [PART_W:0]   pdiff_a, pdiff_b;
  logic              pok_a, pok_b;
  logic [ENERGY_W:0] ediff_a, ediff_b;

  assign pdiff_a = {1'b0, pa_in} - {1'b0, part_floor};
  assign pdiff_b = {1'b0, pb_in} - {1'b0, part_floor};
  assign pok_a   = !pdiff_a[PART_W] && (pdiff_a[PART_W-1:0] < PART_W'(PART_BINS));
  assign pok_b   = !pdiff_b[PART_W] && (pdiff_b[PART_W-1:0] < PART_W'(PART_BINS));
  assign ediff_a = {ea_in[ENERGY_W-1], ea_in} - {energy_floor[ENERGY_W-1], energy_floor};
  assign ediff_b = {eb_in[ENERGY_W-1], eb_in} - {energy_floor[ENERGY_W-1], energy_floor};

  logic              part_ok;
  logic [AW-1:0]     part_idx;
  logic [ENERGY_W:0] ediff_a_r, ediff_b_r;

  always_ff @(posedge clk) begin
    if (state == S_DIFF) begin
      part_ok   <= pok_a && pok_b;
      part_idx  <= AW'(pdiff_a[PB_W-1:0]) * AW'(PART_BINS) + AW'(pdiff_b[PB_W-1:0]);
      ediff_a_r <= ediff_a;
      ediff_b_r <= ediff_b;
    end
  end

  // Multiply stage: scale offsets by the reciprocal width, keep integer part
  logic [63:0] prod_a, prod_b;
  assign prod_a = ediff_a_r[ENERGY_W-1:0] * inv_bin_width;
  assign prod_b = ediff_b_r[ENERGY_W-1:0] * inv_bin_width;

  logic        neg_a, neg_b;
  logic [31:0] eidx_a, eidx_b;
  logic        part_ok_m;
  logic [AW-1:0] part_idx_m;

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      neg_a      <= ediff_a_r[ENERGY_W];
      neg_b      <= ediff_b_r[ENERGY_W];
      eidx_a     <= prod_a[63:32];
      eidx_b     <= prod_b[63:32];
      part_ok_m  <= part_ok;
      part_idx_m <= part_idx;
    end
  end

  // Address stage: range checks, flat index, issue the memory read
  logic          rec_ok;
  logic [AW-1:0] flat;
  logic          rd_in_range;

  assign rec_ok = part_ok_m && !neg_a && !neg_b
               && (eidx_a < 32'(ENERGY_BINS)) && (eidx_b < 32'(ENERGY_BINS));
  assign flat   = (part_idx_m * AW'(ENERGY_BINS) + AW'(eidx_a[EB_W-1:0])) * AW'(ENERGY_BINS)
                + AW'(eidx_b[EB_W-1:0]);
  assign rd_in_range = (64'(rd_addr) < 64'(NUM_BINS));

  logic          hit;
  logic [AW-1:0] flat_r;

  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      hit    <= (op == OP_READ) ? rd_in_range : rec_ok;
      flat_r <= flat;
    end
  end

  // Counter memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, clr_addr;
  count_t        ram_wdata, ram_rdata, bumped;

  assign ram_raddr = (op == OP_READ) ? AW'(rd_addr) : flat;
  assign bumped    = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_W'(1);
  assign ram_we    = (state == S_CLEAR) || ((state == S_RMW) && (op == OP_RECORD) && hit);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : flat_r;
  assign ram_wdata = (state == S_CLEAR) ? '0 : bumped;

  jehb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE:  if (take) state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL;
      S_MUL:   state_next = S_ADDR;
      S_ADDR:  state_next = S_RMW;
      S_RMW:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Result word: hold for one cycle after the write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_RMW);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RMW) begin
      accepted  <= (op == OP_RECORD) && hit;
      if (!hit) begin
        bin_count <= '0;
      end else if (op == OP_RECORD) begin
        bin_count <= bumped;
      end else begin
        bin_count <= ram_rdata;
      end
    end
  end

  // Checks
  a_done_after_rmw: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RMW))
    else $error("result word without a write-back cycle");

  a_accept_needs_done: assert property (@(posedge clk) disable iff (rst)
    accepted && done |-> bin_count != '0)
    else $error("counted event reports a zero count");

  a_write_only_clear_or_rmw: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_RMW))
    else $error("counter write outside clear or write-back");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (state == S_CLEAR && busy))
    else $error("no clearing sweep after reset");

endmodule

// ===== design/jehb_ram.sv =====
module jehb_ram #(
  parameter int WIDTH = 32,
  parameter longint unsigned DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/histogram_tracker_pkg.sv =====
`timescale 1ns / 1ps
package histogram_tracker_pkg;
  import jehb_pkg::*;

  localparam int PART_BINS   = 8;
  localparam int ENERGY_BINS = 32;
  localparam int HIST_BINS   = PART_BINS * PART_BINS * ENERGY_BINS * ENERGY_BINS;

  typedef struct {
    logic               opcode;
    part_t              pa;
    part_t              pb;
    energy_t            ea;
    energy_t            eb;
    logic [RADDR_W-1:0] addr;
  } hist_cmd_t;

  typedef struct {
    logic   accepted;
    count_t count;
  } result_word_t;

  // Tracks the expected histogram and the result words still owed by the block.
  class histogram_tracker;
    bit [COUNT_W-1:0] counts [HIST_BINS];
    part_t            part_floor;
    energy_t          energy_floor;
    logic [31:0]      energy_scale;
    result_word_t     pending[$];
    int unsigned      hit_bins[$];
    int unsigned      errors;
    int unsigned      commands;
    int unsigned      binned;
    int unsigned      reads;

    function new();
      part_floor   = '0;
      energy_floor = '0;
      energy_scale = INV_WIDTH_RESET;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_PART_FLOOR:    part_floor   = data[PART_W-1:0];
        CFG_ENERGY_FLOOR:  energy_floor = data;
        CFG_INV_BIN_WIDTH: energy_scale = data;
        default: ;
      endcase
    endfunction

    function bit particle_slot(part_t p, output int unsigned slot);
      if (p < part_floor) return 1'b0;
      if (p - part_floor >= PART_BINS) return 1'b0;
      slot = 32'(p - part_floor);
      return 1'b1;
    endfunction

    // Exact 33-bit difference, then the integer part of the Q32.32 product.
    function bit energy_slot(energy_t e, output int unsigned slot);
      logic [32:0] diff;
      logic [63:0] prod;
      diff = {e[ENERGY_W-1], e} - {energy_floor[ENERGY_W-1], energy_floor};
      if (diff[32]) return 1'b0;
      prod = {32'd0, diff[31:0]} * {32'd0, energy_scale};
      if (prod[63:32] >= ENERGY_BINS) return 1'b0;
      slot = prod[63:32];
      return 1'b1;
    endfunction

    function void note_command(hist_cmd_t c);
      result_word_t w;
      int unsigned  pa, pb, ea, eb, flat;
      w.accepted = 1'b0;
      w.count    = '0;
      commands++;
      if (c.opcode == OP_READ) begin
        reads++;
        if (c.addr < HIST_BINS) w.count = counts[c.addr];
      end else if (particle_slot(c.pa, pa) && particle_slot(c.pb, pb) &&
                   energy_slot(c.ea, ea) && energy_slot(c.eb, eb)) begin
        flat = ((pa * PART_BINS + pb) * ENERGY_BINS + ea) * ENERGY_BINS + eb;
        if (counts[flat] != COUNT_MAX) counts[flat]++;
        w.accepted = 1'b1;
        w.count    = counts[flat];
        binned++;
        hit_bins.push_back(flat);
      end
      pending.push_back(w);
    endfunction

    function void check_word(logic acc, count_t cnt);
      result_word_t w;
      if (pending.size() == 0) begin
        $error("result word with no command outstanding: accepted %0d, bin_count %0d",
               acc, cnt);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (acc !== w.accepted) begin
        $error("accepted: expected %0d, got %0d", w.accepted, acc);
        errors++;
      end
      if (cnt !== w.count) begin
        $error("bin_count: expected %0d, got %0d", w.count, cnt);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/joint_energy_histogram_binner_test.sv =====
`timescale 1ns / 1ps
module joint_energy_histogram_binner_test;
  import jehb_pkg::*;
  import histogram_tracker_pkg::*;

  // Clearing sweep of 65536 entries plus ~870 commands with short gaps,
  // taken several times over.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int DRAIN_CYCLES  = 10;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  logic               opcode       = OP_RECORD;
  part_t              particles_a  = '0;
  part_t              particles_b  = '0;
  energy_t            energy_a     = '0;
  energy_t            energy_b     = '0;
  logic [RADDR_W-1:0] read_address = '0;
  logic               cfg_valid    = 1'b0;
  cfg_idx_t           cfg_index    = CFG_PART_FLOOR;
  logic [31:0]        cfg_data     = '0;
  logic               busy;
  logic               done;
  logic               accepted;
  count_t             bin_count;
  logic               cfg_ready;

  histogram_tracker hist = new();
  int unsigned      idle_pct        = 7;
  int unsigned      settings_loaded = 0;
  int unsigned      cycles          = 0;

  joint_energy_histogram_binner #(
    .PART_BINS  (PART_BINS),
    .ENERGY_BINS(ENERGY_BINS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .particles_a (particles_a),
    .particles_b (particles_b),
    .energy_a    (energy_a),
    .energy_b    (energy_b),
    .read_address(read_address),
    .done        (done),
    .accepted    (accepted),
    .bin_count   (bin_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Abort on a hang: the clearing sweep or a lost result word.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result words last exactly one cycle; sample mid-cycle so the check never
  // races the edge that produced them.
  always @(negedge clk) begin
    if (!rst && done) hist.check_word(accepted, bin_count);
  end

  // Drive one command word and hold it until start && !busy lands on an edge.
  // An idle gap drops start first; otherwise start stays high from the
  // previous word so it is never lowered and raised in one step.
  task automatic issue(input hist_cmd_t c);
    bit free;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    start        <= 1'b1;
    opcode       <= c.opcode;
    particles_a  <= c.pa;
    particles_b  <= c.pb;
    energy_a     <= c.ea;
    energy_b     <= c.eb;
    read_address <= c.addr;
    // busy is sampled at the falling edge, so it is the value the next
    // rising edge sees.
    do begin
      @(negedge clk);
      free = !busy;
      @(posedge clk);
    end while (!free);
    hist.note_command(c);
  endtask

  // Event word with a junk read address, which the block must ignore.
  task automatic send_event(input part_t pa, input part_t pb, input energy_t ea,
                            input energy_t eb);
    hist_cmd_t c;
    c.opcode = OP_RECORD;
    c.pa     = pa;
    c.pb     = pb;
    c.ea     = ea;
    c.eb     = eb;
    c.addr   = RADDR_W'($urandom);
    issue(c);
  endtask

  // Read word with junk event fields, which the block must ignore.
  task automatic send_read(input logic [RADDR_W-1:0] addr);
    hist_cmd_t c;
    c.opcode = OP_READ;
    c.pa     = part_t'($urandom);
    c.pb     = part_t'($urandom);
    c.ea     = energy_t'($urandom);
    c.eb     = energy_t'($urandom);
    c.addr   = addr;
    issue(c);
  endtask

  // Drop start and wait until every owed result word has come back.
  task automatic settle();
    start <= 1'b0;
    while (hist.pending.size() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; valid stays high between words.
  task automatic load_setting(input part_t floor_p, input energy_t floor_e,
                              input logic [31:0] scale);
    logic [31:0] vals [3];
    cfg_idx_t    idx  [3];
    bit          ready_seen;
    vals = '{{16'd0, floor_p}, floor_e, scale};
    idx  = '{CFG_PART_FLOOR, CFG_ENERGY_FLOOR, CFG_INV_BIN_WIDTH};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do begin
        @(negedge clk);
        ready_seen = cfg_ready;
        @(posedge clk);
      end while (!ready_seen);
      hist.set_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Particle count mostly inside the configured window, sometimes just outside.
  function automatic part_t pick_part();
    int v;
    case ($urandom_range(19))
      0:       v = int'(hist.part_floor) - 1 - int'($urandom_range(3));
      1:       v = int'(hist.part_floor) + PART_BINS + int'($urandom_range(3));
      default: v = int'(hist.part_floor) + int'($urandom_range(PART_BINS - 1));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return part_t'(v);
  endfunction

  // Energy aimed at the configured bins: span is the smallest difference that
  // falls past the last bin, so offsets below it land in range.
  function automatic energy_t pick_energy();
    longint          span, off, e;
    longint unsigned r;
    if (hist.energy_scale == 0) span = 64'sh1_0000_0000;
    else span = ((longint'(ENERGY_BINS) << 32) + longint'(hist.energy_scale) - 1) /
                longint'(hist.energy_scale);
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       off = -1 - longint'($urandom_range(1000));
      1:       off = span + longint'($urandom_range(1000));
      default: off = longint'(r % span);
    endcase
    e = longint'(hist.energy_floor) + off;
    if (e > 64'sh7FFF_FFFF) e = 64'sh7FFF_FFFF;
    if (e < -64'sh8000_0000) e = -64'sh8000_0000;
    return energy_t'(e);
  endfunction

  // Mostly well-aimed events, some single-bin reads (biased to bins already
  // hit), and some fully random noise words.
  task automatic run_random(input int unsigned n);
    hist_cmd_t c;
    repeat (n) begin
      c.opcode = OP_RECORD;
      c.pa     = part_t'($urandom);
      c.pb     = part_t'($urandom);
      c.ea     = energy_t'($urandom);
      c.eb     = energy_t'($urandom);
      c.addr   = RADDR_W'($urandom);
      case ($urandom_range(19))
        0, 1, 2: begin
          c.opcode = OP_READ;
          if (hist.hit_bins.size() != 0 && $urandom_range(2) != 0)
            c.addr = RADDR_W'(hist.hit_bins[$urandom_range(hist.hit_bins.size() - 1)]);
        end
        3, 4: ;
        default: begin
          c.pa = pick_part();
          c.pb = pick_part();
          c.ea = pick_energy();
          c.eb = pick_energy();
        end
      endcase
      issue(c);
    end
  endtask

  initial begin
    logic [31:0] scale;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: unit bin width, both floors at zero.
    send_event(16'd0, 16'd0, 32'h0000_0000, 32'h0000_0000);
    send_event(16'd0, 16'd0, 32'h0000_FFFF, 32'h0000_0000);   // same bin, count 2
    send_event(16'd7, 16'd7, 32'h001F_FFFF, 32'h001F_FFFF);   // top corner bin
    send_event(16'd8, 16'd0, 32'h0000_0000, 32'h0000_0000);   // particle bin too high
    send_event(16'd0, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);
    send_event(16'd0, 16'd0, 32'hFFFF_FFFF, 32'h0000_0000);   // below min energy
    send_event(16'd0, 16'd0, 32'h0000_0000, 32'h0020_0000);   // energy bin too high
    send_event(16'd0, 16'd0, 32'h7FFF_FFFF, 32'h0000_0000);
    send_event(16'd0, 16'd0, 32'h0000_0000, 32'h8000_0000);
    send_read(16'h0000);
    send_read(16'hFFFF);
    send_read(16'h1234);
    send_event(16'd3, 16'd5, 32'h000A_8000, 32'h0001_0000);
    send_read(16'((((3 * PART_BINS + 5) * ENERGY_BINS + 10) * ENERGY_BINS) + 1));
    run_random(200);

    // Shifted floors, bin width two, particle floor above zero.
    settle();
    load_setting(16'd3, 32'hFFFA_8000, 32'h0000_8000);
    send_event(16'd2, 16'd3, 32'h0000_0000, 32'h0000_0000);   // below particle floor
    send_event(16'd3, 16'd10, 32'hFFFA_8000, 32'hFFFA_8000);
    send_event(16'd3, 16'd3, 32'hFFFA_7FFF, 32'h0000_0000);   // just under energy floor
    run_random(150);

    // Zero reciprocal width from the lowest floor: everything in energy bin 0.
    settle();
    load_setting(16'd0, 32'h8000_0000, 32'h0000_0000);
    send_event(16'd0, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    run_random(80);

    // Top of every register range.
    settle();
    load_setting(16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_event(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_event(16'hFFFE, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_read(16'h0000);
    run_random(80);

    // Random settings, the last ones with the sender never idling.
    repeat (3) begin
      settle();
      case ($urandom_range(2))
        0:       scale = $urandom;
        1:       scale = $urandom_range(1, 32'h0004_0000);
        default: scale = 32'h1 << $urandom_range(31);
      endcase
      load_setting(part_t'($urandom_range(40)), energy_t'($urandom), scale);
      run_random(80);
      idle_pct = 0;
    end

    // Back to the reset setting.
    settle();
    load_setting(16'd0, 32'h0000_0000, INV_WIDTH_RESET);
    run_random(100);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d command words over %0d register settings: %0d events binned,",
             hist.commands, settings_loaded + 1, hist.binned);
    $display("%0d single-bin reads, the rest dropped out of range.", hist.reads);
    if (hist.errors == 0 && hist.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
